// ----- design/thcs_pkg.sv -----
// ----------------------------------------------------------------------------
// thcs_pkg: shared types and helpers for the track/hit chi-square block
// Word formats between the front, the arithmetic pipe and the divider.
// ----------------------------------------------------------------------------
package thcs_pkg;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   localparam logic signed [39:0] SAT_HI = 40'sh00_7FFF_FFFF;
   localparam logic signed [39:0] SAT_LO = 40'shFF_8000_0000;

   typedef enum logic {
      KIND_STRIP = 1'b0,
      KIND_PIXEL = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [31:0] track_x;
      logic signed [31:0] track_y;
      logic signed [31:0] cov_xx;
      logic signed [31:0] cov_xy;
      logic signed [31:0] cov_yy;
      logic signed [31:0] hit_pos_a;
      logic signed [31:0] hit_y_or_sin;
      logic signed [31:0] hit_err_a;
      logic signed [31:0] hit_err_b;
      logic signed [31:0] hit_dxy_or_cos;
   } fields_type;

   typedef struct packed {
      kind_type   kind;
      fields_type f;
   } item_type;

   typedef struct packed {
      logic               ovf;
      logic signed [31:0] val;
   } sat_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] num;
      logic signed [31:0] den;
      logic               zero_den;
      logic               flag;
   } div_in_type;

   typedef struct packed {
      logic signed [31:0] chi_square;
      logic               saturated;
   } rsp_type;

   // Clamp a widened sum to 32 bits and report the clamp.
   function automatic sat_type sat40(input logic signed [39:0] v);
      sat_type r;
      r.ovf = 1'b0;
      r.val = v[31:0];
      if (v > SAT_HI) begin
         r.ovf = 1'b1;
         r.val = Q_MAX;
      end else if (v < SAT_LO) begin
         r.ovf = 1'b1;
         r.val = Q_MIN;
      end
      return r;
   endfunction

endpackage

// ----- design/thcs_fifo.sv -----
// ----------------------------------------------------------------------------
// thcs_fifo: small register FIFO
// Generic first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module thcs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    count_ff;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wp_ff <= (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
         end
         if (do_rd) begin
            rp_ff <= (rp_ff == LAST) ? '0 : rp_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- design/thcs_front.sv -----
// ----------------------------------------------------------------------------
// thcs_front: input stage
// Take request words, tag the hit kind and hand them to the work queue.
// ----------------------------------------------------------------------------
module thcs_front import thcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_mode,
   input  fields_type req_fields,
   output logic       q_wr,
   output item_type   q_item,
   input  logic       q_full
);

   logic     valid_ff;
   item_type item_ff, item_in;
   logic     accept;

   assign full   = valid_ff && q_full;
   assign accept = push && !full;
   assign q_wr   = valid_ff && !q_full;
   assign q_item = item_ff;

   always_comb begin
      item_in.kind = req_mode ? KIND_PIXEL : KIND_STRIP;
      item_in.f    = req_fields;
      // drop the pixel-only error for strip hits
      if (!req_mode) begin
         item_in.f.hit_err_b = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (q_wr) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- design/thcs_calc.sv -----
// ----------------------------------------------------------------------------
// thcs_calc: residual and covariance arithmetic
// Three multiply/round pairs form the numerator and denominator.
// ----------------------------------------------------------------------------
module thcs_calc import thcs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  item_type   in_item,
   output div_in_type div_in
);

   localparam logic [63:0] RND = 64'd1 << (FRAC_BITS - 1);

   function automatic sat_type qround(input logic signed [63:0] p);
      logic [63:0] m, rm;
      sat_type     r;
      m = p[63] ? (64'd0 - $unsigned(p)) : $unsigned(p);
      rm = (m + RND) >> FRAC_BITS;
      if (!p[63]) begin
         r.ovf = (rm > 64'h0000_0000_7FFF_FFFF);
         r.val = r.ovf ? Q_MAX : $signed(rm[31:0]);
      end else begin
         r.ovf = (rm > 64'h0000_0000_8000_0000);
         r.val = r.ovf ? Q_MIN : $signed(32'd0 - rm[31:0]);
      end
      return r;
   endfunction

   // ---- stage 1: first products
   logic signed [31:0] opa1 [6];
   logic signed [31:0] opb1 [6];
   logic               v1_ff;
   item_type           it1_ff;
   logic signed [63:0] p1_ff [6];

   always_comb begin
      case (in_item.kind)
         KIND_STRIP: begin
            opa1[0] = in_item.f.hit_dxy_or_cos; opb1[0] = in_item.f.hit_dxy_or_cos;
            opa1[1] = in_item.f.hit_y_or_sin;   opb1[1] = in_item.f.hit_y_or_sin;
            opa1[2] = in_item.f.hit_dxy_or_cos; opb1[2] = in_item.f.hit_y_or_sin;
            opa1[3] = in_item.f.hit_err_a;      opb1[3] = in_item.f.hit_err_a;
            opa1[4] = in_item.f.track_x;        opb1[4] = in_item.f.hit_dxy_or_cos;
            opa1[5] = in_item.f.track_y;        opb1[5] = in_item.f.hit_y_or_sin;
         end
         default: begin
            opa1[0] = in_item.f.hit_err_a;      opb1[0] = in_item.f.hit_err_a;
            opa1[1] = in_item.f.hit_err_b;      opb1[1] = in_item.f.hit_err_b;
            opa1[2] = in_item.f.hit_dxy_or_cos; opb1[2] = in_item.f.hit_dxy_or_cos;
            opa1[3] = in_item.f.hit_dxy_or_cos; opb1[3] = in_item.f.cov_xy;
            opa1[4] = in_item.f.cov_xy;         opb1[4] = in_item.f.cov_xy;
            opa1[5] = in_item.f.cov_xx;         opb1[5] = in_item.f.cov_yy;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff <= in_item;
         for (int k = 0; k < 6; k++) begin
            p1_ff[k] <= opa1[k] * opb1[k];
         end
      end
   end

   // ---- stage 2: round, residuals, first differences
   sat_type            r1 [6];
   sat_type            sc2, ru, xr, yr, ea, eb, ec;
   logic               f1;
   logic               v2_ff, f2_ff;
   kind_type           kind2_ff;
   logic signed [31:0] r2_ff [6];
   logic signed [31:0] sc2_ff, ru_ff, xr2_ff, yr2_ff, a2_ff, b2_ff, c2_ff;
   logic signed [31:0] c0_2_ff, c1_2_ff, c5_2_ff;

   always_comb begin
      f1 = 1'b0;
      for (int k = 0; k < 6; k++) begin
         r1[k] = qround(p1_ff[k]);
         f1    = f1 | r1[k].ovf;
      end
      sc2 = sat40(40'(r1[2].val) + 40'(r1[2].val));
      ru  = sat40(40'(it1_ff.f.hit_pos_a) - 40'(r1[4].val) - 40'(r1[5].val));
      xr  = sat40(40'(it1_ff.f.hit_pos_a) - 40'(it1_ff.f.track_x));
      yr  = sat40(40'(it1_ff.f.hit_y_or_sin) - 40'(it1_ff.f.track_y));
      ea  = sat40(40'(r1[1].val) - 40'(it1_ff.f.cov_yy));
      eb  = sat40(40'(it1_ff.f.hit_dxy_or_cos) - 40'(it1_ff.f.cov_xy));
      ec  = sat40(40'(r1[0].val) - 40'(it1_ff.f.cov_xx));
      case (it1_ff.kind)
         KIND_STRIP: f1 = f1 | sc2.ovf | ru.ovf;
         default:    f1 = f1 | xr.ovf | yr.ovf | ea.ovf | eb.ovf | ec.ovf;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff <= it1_ff.kind;
         f2_ff    <= f1;
         for (int k = 0; k < 6; k++) begin
            r2_ff[k] <= r1[k].val;
         end
         sc2_ff  <= sc2.val;
         ru_ff   <= ru.val;
         xr2_ff  <= xr.val;
         yr2_ff  <= yr.val;
         a2_ff   <= ea.val;
         b2_ff   <= eb.val;
         c2_ff   <= ec.val;
         c0_2_ff <= it1_ff.f.cov_xx;
         c1_2_ff <= it1_ff.f.cov_xy;
         c5_2_ff <= it1_ff.f.cov_yy;
      end
   end

   // ---- stage 3: second products
   logic signed [31:0] opa3 [7];
   logic signed [31:0] opb3 [7];
   logic               v3_ff, f3_ff;
   kind_type           kind3_ff;
   logic signed [63:0] p3_ff [7];
   logic signed [31:0] m3_ff [4];
   logic signed [31:0] xr3_ff, yr3_ff;

   always_comb begin
      case (kind2_ff)
         KIND_STRIP: begin
            opa3[0] = r2_ff[0]; opb3[0] = c0_2_ff;
            opa3[1] = sc2_ff;   opb3[1] = c1_2_ff;
            opa3[2] = r2_ff[1]; opb3[2] = c5_2_ff;
            opa3[3] = ru_ff;    opb3[3] = ru_ff;
            opa3[4] = '0;       opb3[4] = '0;
            opa3[5] = '0;       opb3[5] = '0;
            opa3[6] = '0;       opb3[6] = '0;
         end
         default: begin
            opa3[0] = r2_ff[0]; opb3[0] = r2_ff[1];
            opa3[1] = r2_ff[0]; opb3[1] = c5_2_ff;
            opa3[2] = r2_ff[1]; opb3[2] = c0_2_ff;
            opa3[3] = xr2_ff;   opb3[3] = a2_ff;
            opa3[4] = yr2_ff;   opb3[4] = b2_ff;
            opa3[5] = yr2_ff;   opb3[5] = c2_ff;
            opa3[6] = xr2_ff;   opb3[6] = b2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind3_ff <= kind2_ff;
         f3_ff    <= f2_ff;
         for (int k = 0; k < 7; k++) begin
            p3_ff[k] <= opa3[k] * opb3[k];
         end
         for (int k = 0; k < 4; k++) begin
            m3_ff[k] <= r2_ff[k+2];
         end
         xr3_ff <= xr2_ff;
         yr3_ff <= yr2_ff;
      end
   end

   // ---- stage 4: denominator or norm, pixel partial terms
   sat_type            q3 [7];
   sat_type            den, norm, t1, t2;
   logic               f3;
   logic               v4_ff, f4_ff;
   kind_type           kind4_ff;
   logic signed [31:0] den4_ff, num4_ff, t1_4_ff, t2_4_ff, xr4_ff, yr4_ff;

   always_comb begin
      f3 = f3_ff;
      for (int k = 0; k < 7; k++) begin
         q3[k] = qround(p3_ff[k]);
         f3    = f3 | q3[k].ovf;
      end
      // strip: du^2 minus projected track variance
      den  = sat40(40'(m3_ff[1]) - 40'(q3[0].val) - 40'(q3[1].val) - 40'(q3[2].val));
      // pixel: determinant of (hit cov - track cov)
      norm = sat40(40'(q3[0].val) - 40'(q3[1].val) - 40'(q3[2].val) + 40'(m3_ff[3])
                   - 40'(m3_ff[0]) + 40'(m3_ff[1]) + 40'(m3_ff[1]) - 40'(m3_ff[2]));
      t1   = sat40(40'(q3[3].val) - 40'(q3[4].val));
      t2   = sat40(40'(q3[5].val) - 40'(q3[6].val));
      case (kind3_ff)
         KIND_STRIP: f3 = f3 | den.ovf;
         default:    f3 = f3 | norm.ovf | t1.ovf | t2.ovf;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind4_ff <= kind3_ff;
         f4_ff    <= f3;
         den4_ff  <= (kind3_ff == KIND_STRIP) ? den.val : norm.val;
         num4_ff  <= q3[3].val;
         t1_4_ff  <= t1.val;
         t2_4_ff  <= t2.val;
         xr4_ff   <= xr3_ff;
         yr4_ff   <= yr3_ff;
      end
   end

   // ---- stage 5: pixel quadratic form products
   logic               v5_ff, f5_ff;
   kind_type           kind5_ff;
   logic signed [63:0] pa5_ff, pb5_ff;
   logic signed [31:0] den5_ff, num5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind5_ff <= kind4_ff;
         f5_ff    <= f4_ff;
         pa5_ff   <= t1_4_ff * xr4_ff;
         pb5_ff   <= t2_4_ff * yr4_ff;
         den5_ff  <= den4_ff;
         num5_ff  <= num4_ff;
      end
   end

   // ---- stage 6: final numerator, zero checks
   sat_type    qa, qb, pnum;
   div_in_type div_in_in, div_in_ff;

   always_comb begin
      qa   = qround(pa5_ff);
      qb   = qround(pb5_ff);
      pnum = sat40(40'(qa.val) + 40'(qb.val));
      div_in_in.valid = v5_ff;
      case (kind5_ff)
         KIND_STRIP: begin
            div_in_in.num      = num5_ff;
            div_in_in.den      = den5_ff;
            div_in_in.zero_den = (den5_ff == '0);
            div_in_in.flag     = f5_ff;
         end
         default: begin
            // replace a zero norm by one LSB
            div_in_in.num      = pnum.val;
            div_in_in.den      = (den5_ff == '0) ? 32'sd1 : den5_ff;
            div_in_in.zero_den = 1'b0;
            div_in_in.flag     = f5_ff | qa.ovf | qb.ovf | pnum.ovf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_in_ff.valid <= 1'b0;
      end else if (adv) begin
         div_in_ff <= div_in_in;
      end
   end

   assign div_in = div_in_ff;

endmodule

// ----- design/thcs_div.sv -----
// ----------------------------------------------------------------------------
// thcs_div: pipelined rounding divider
// Restoring division, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module thcs_div import thcs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  div_in_type div_in,
   output logic       res_valid,
   output rsp_type    res
);

   localparam int QW    = 33;
   localparam int STEPS = QW;
   localparam int NW    = QW + FRAC_BITS;

   localparam logic [QW-1:0] NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [QW-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;

   logic [31:0]   rem_ff  [STEPS+1];
   logic [QW-1:0] lo_ff   [STEPS+1];
   logic [QW-1:0] quo_ff  [STEPS+1];
   logic [31:0]   dm_ff   [STEPS+1];
   logic          vld_ff  [STEPS+1];
   logic          neg_ff  [STEPS+1];
   logic          ovf_ff  [STEPS+1];
   logic          zd_ff   [STEPS+1];
   logic          flg_ff  [STEPS+1];

   // ---- setup: magnitudes, rounding offset, early overflow test
   logic [31:0]          nm, dm;
   logic [NW-1:0]        nsh;
   logic [FRAC_BITS-1:0] hi;

   always_comb begin
      nm  = div_in.num[31] ? (32'd0 - $unsigned(div_in.num)) : $unsigned(div_in.num);
      dm  = div_in.den[31] ? (32'd0 - $unsigned(div_in.den)) : $unsigned(div_in.den);
      if (div_in.zero_den) begin
         dm = 32'd1;
      end
      nsh = {1'b0, nm, {FRAC_BITS{1'b0}}} + NW'(dm >> 1);
      hi  = nsh[NW-1:QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= div_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= 32'(hi);
         lo_ff[0]  <= nsh[QW-1:0];
         quo_ff[0] <= '0;
         dm_ff[0]  <= dm;
         neg_ff[0] <= div_in.num[31] ^ div_in.den[31];
         ovf_ff[0] <= (32'(hi) >= dm);
         zd_ff[0]  <= div_in.zero_den;
         flg_ff[0] <= div_in.flag;
      end
   end

   // ---- one quotient bit per stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic [32:0] trial, diff;
      logic        ge;

      assign trial = {rem_ff[k-1], lo_ff[k-1][QW-1]};
      assign ge    = (trial >= {1'b0, dm_ff[k-1]});
      assign diff  = ge ? (trial - {1'b0, dm_ff[k-1]}) : trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= diff[31:0];
            lo_ff[k]  <= lo_ff[k-1] << 1;
            quo_ff[k] <= {quo_ff[k-1][QW-2:0], ge};
            dm_ff[k]  <= dm_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            zd_ff[k]  <= zd_ff[k-1];
            flg_ff[k] <= flg_ff[k-1];
         end
      end
   end

   // ---- sign, saturation and the zero-denominator case
   logic    res_valid_ff;
   rsp_type res_ff, res_in;
   logic [QW-1:0] qf;

   always_comb begin
      qf = quo_ff[STEPS];
      res_in.saturated = flg_ff[STEPS];
      if (zd_ff[STEPS]) begin
         res_in.chi_square = Q_MAX;
         res_in.saturated  = 1'b1;
      end else if (neg_ff[STEPS]) begin
         if (ovf_ff[STEPS] || (qf > NEG_LIMIT)) begin
            res_in.chi_square = Q_MIN;
            res_in.saturated  = 1'b1;
         end else begin
            res_in.chi_square = $signed(32'd0 - qf[31:0]);
         end
      end else begin
         if (ovf_ff[STEPS] || (qf > POS_LIMIT)) begin
            res_in.chi_square = Q_MAX;
            res_in.saturated  = 1'b1;
         end else begin
            res_in.chi_square = $signed(qf[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (adv) begin
         res_valid_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   a_zero_den_max: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[STEPS] && zd_ff[STEPS]) |=>
         (res_valid && res.saturated && (res.chi_square == Q_MAX)))
      else $error("zero denominator did not give a saturated maximum");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(res_valid) && $stable(res)))
      else $error("divider result moved during a stall");

   a_sign: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[STEPS] && !neg_ff[STEPS]) |=> !res.chi_square[31])
      else $error("non-negative quotient came out negative");

endmodule

// ----- design/track_hit_chi_square.sv -----
// ----------------------------------------------------------------------------
// track_hit_chi_square: chi-square of a track-to-hit residual
// Strip or pixel hit against a track, one saturating fixed-point result per word.
// ----------------------------------------------------------------------------
// The block takes one request word per clock and returns one result word per
// request, in order. Throughput is one word per cycle with no bubbles while
// the back end is not held. On its way a word passes one front register, the
// work queue, six arithmetic stages (three multiply/round pairs), and the
// divider, which makes one quotient bit per stage over 33 stages plus setup
// and sign stages, and then enters the result queue.
// When a finished word meets a full result queue the whole back end holds; the
// front and the work queue keep taking words until the queue fills, then full
// rises.
// chi_square is signed fixed point with FRAC_BITS fraction bits; saturated
// marks any clamp on the way, and a zero strip denominator returns the largest
// positive value with saturated set.
module track_hit_chi_square import thcs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_mode,
   input  logic signed [31:0] req_track_x,
   input  logic signed [31:0] req_track_y,
   input  logic signed [31:0] req_cov_xx,
   input  logic signed [31:0] req_cov_xy,
   input  logic signed [31:0] req_cov_yy,
   input  logic signed [31:0] req_hit_pos_a,
   input  logic signed [31:0] req_hit_y_or_sin,
   input  logic signed [31:0] req_hit_err_a,
   input  logic signed [31:0] req_hit_err_b,
   input  logic signed [31:0] req_hit_dxy_or_cos,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_chi_square,
   output logic               rsp_saturated
);

   localparam int WORK_DEPTH = 4;
   localparam int RSP_DEPTH  = 2;

   fields_type req_fields;
   item_type   front_item, work_item;
   logic       front_wr, work_full, work_empty, work_rd;
   logic       adv;
   div_in_type div_in;
   logic       res_valid, rsp_full, rsp_wr;
   rsp_type    res, rsp_word;

   // gather the request ports into one word
   assign req_fields.track_x        = req_track_x;
   assign req_fields.track_y        = req_track_y;
   assign req_fields.cov_xx         = req_cov_xx;
   assign req_fields.cov_xy         = req_cov_xy;
   assign req_fields.cov_yy         = req_cov_yy;
   assign req_fields.hit_pos_a      = req_hit_pos_a;
   assign req_fields.hit_y_or_sin   = req_hit_y_or_sin;
   assign req_fields.hit_err_a      = req_hit_err_a;
   assign req_fields.hit_err_b      = req_hit_err_b;
   assign req_fields.hit_dxy_or_cos = req_hit_dxy_or_cos;

   // front: accept and tag the hit kind
   thcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_mode   (req_mode),
      .req_fields (req_fields),
      .q_wr       (front_wr),
      .q_item     (front_item),
      .q_full     (work_full)
   );

   // work queue between front and back
   thcs_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (WORK_DEPTH)
   ) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_wr),
      .wr_data (front_item),
      .full    (work_full),
      .rd_en   (work_rd),
      .rd_data (work_item),
      .empty   (work_empty)
   );

   // advance the back end unless a finished word has nowhere to go
   assign adv     = !(res_valid && rsp_full);
   assign work_rd = adv && !work_empty;

   thcs_calc #(
      .FRAC_BITS (FRAC_BITS)
   ) u_calc (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (!work_empty),
      .in_item  (work_item),
      .div_in   (div_in)
   );

   thcs_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .div_in    (div_in),
      .res_valid (res_valid),
      .res       (res)
   );

   // result queue: hold finished words until popped
   assign rsp_wr = adv && res_valid;

   thcs_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr),
      .wr_data (res),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_word),
      .empty   (empty)
   );

   assign rsp_chi_square = rsp_word.chi_square;
   assign rsp_saturated  = rsp_word.saturated;

endmodule
